FILE: design/gtf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gtf_pkg;

  localparam int unsigned ElemW   = 20;
  localparam int unsigned TeamIdW = 4;

  typedef enum logic {
    OpEnq = 1'b0,
    OpDeq = 1'b1
  } gtf_op_e;

  typedef enum logic [1:0] {
    StEnq   = 2'd0,
    StDeq   = 2'd1,
    StEmpty = 2'd2,
    StFull  = 2'd3
  } gtf_status_e;

  typedef struct packed {
    gtf_status_e        status;
    logic [ElemW-1:0]   element;
  } gtf_result_t;

endpackage

`default_nettype wire

FILE: design/gtf_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gtf_in_if;
  logic                           valid;
  logic                           ready;
  gtf_pkg::gtf_op_e               op;
  logic [gtf_pkg::ElemW-1:0]      element;
  logic [gtf_pkg::TeamIdW-1:0]    team_id;

  modport source (output valid, output op, output element, output team_id, input ready);
  modport sink   (input valid, input op, input element, input team_id, output ready);
endinterface

interface gtf_out_if;
  logic                           valid;
  logic                           ready;
  logic [gtf_pkg::ElemW-1:0]      out_element;
  gtf_pkg::gtf_status_e           status;

  modport source (output valid, output out_element, output status, input ready);
  modport sink   (input valid, input out_element, input status, output ready);
endinterface

`default_nettype wire

FILE: design/gtf_out_skid.sv
`timescale 1ns / 1ps
`default_nettype none

// Result register plus one skid entry: the input side keeps moving while a
// result waits on the output.
module gtf_out_skid (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic                 res_valid_i,
  input  wire gtf_pkg::gtf_result_t res_i,
  output      logic                 res_pop_o,
  gtf_out_if.source                 out_o
);

  logic                 skid_valid_q;
  gtf_pkg::gtf_result_t skid_q;
  logic                 out_fire;
  logic                 in_fire;
  gtf_pkg::gtf_result_t shown;

  always_comb begin
    shown             = skid_valid_q ? skid_q : res_i;
    out_o.valid       = skid_valid_q | res_valid_i;
    out_o.out_element = shown.element;
    out_o.status      = shown.status;
    out_fire          = out_o.valid & out_o.ready;
    in_ready_o        = ~skid_valid_q;
    in_fire           = in_valid_i & in_ready_o;
    res_pop_o         = out_fire & ~skid_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire && res_valid_i && !res_pop_o) begin
      skid_valid_q <= 1'b1;
    end
  end

  // stalled result parks here while the new transaction takes the result slot
  always_ff @(posedge clk_i) begin
    if (!skid_valid_q && in_fire && res_valid_i && !res_pop_o) begin
      skid_q <= res_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/grouped_team_fifo_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Team queue: one transaction per clock, enqueue or dequeue. Team order, team
// heads and counts live in flops and are updated at the accepting edge; the
// element store is a single memory of NUM_TEAMS*TEAM_DEPTH words with one
// registered read, so each result and its status are registered before they
// are shown. A result register and one skid entry sit at the output, so input
// is taken every cycle unless two results are waiting. No clearing pass is
// needed after reset.
module grouped_team_fifo_unit #(
  parameter int unsigned NUM_TEAMS    = 16,
  parameter int unsigned TEAM_DEPTH   = 64,
  parameter int unsigned ELEMENT_BITS = 20
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gtf_in_if.sink     in_i,
  gtf_out_if.source  out_o
);

  localparam int unsigned OW   = (NUM_TEAMS > 1) ? $clog2(NUM_TEAMS) : 1;
  localparam int unsigned OCW  = $clog2(NUM_TEAMS + 1);
  localparam int unsigned SLW  = (TEAM_DEPTH > 1) ? $clog2(TEAM_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(TEAM_DEPTH + 1);
  localparam int unsigned STORE_DEPTH = NUM_TEAMS * TEAM_DEPTH;
  localparam int unsigned AW   = $clog2(STORE_DEPTH);
  localparam int unsigned SW   = (ELEMENT_BITS < gtf_pkg::ElemW) ? ELEMENT_BITS
                                                                 : gtf_pkg::ElemW;

  logic [OW-1:0]  team_order_q [NUM_TEAMS];
  logic [OW-1:0]  order_head_q;
  logic [OCW-1:0] order_count_q;
  logic [SLW-1:0] member_head_q [NUM_TEAMS];
  logic [CW-1:0]  member_count_q [NUM_TEAMS];
  logic [SW-1:0]  store_mem [STORE_DEPTH];
  logic [SW-1:0]  rd_data_q;
  logic           res_valid_q;
  gtf_pkg::gtf_status_e res_status_q;

  logic           in_ready;
  logic           res_pop;
  logic           fire_in;
  logic           is_deq;
  logic [31:0]    team_ext;
  logic           team_ok;
  logic [OW-1:0]  front_team;
  logic [OW-1:0]  idx;
  logic [CW-1:0]  cnt;
  logic [SLW-1:0] head;
  logic [OCW:0]   tail_sum;
  logic [OW-1:0]  order_tail;
  logic [OW:0]    order_head_inc;
  logic [OW-1:0]  order_head_nxt;
  logic [SLW:0]   head_inc;
  logic [SLW-1:0] head_nxt;
  logic [CW:0]    slot_sum;
  logic [SLW-1:0] slot_tail;
  logic [SLW-1:0] slot;
  logic [AW-1:0]  store_addr;
  logic           do_deq;
  logic           do_enq;
  logic           new_team;
  gtf_pkg::gtf_status_e status_d;
  gtf_pkg::gtf_result_t res;

  assign in_i.ready = in_ready;
  assign fire_in    = in_i.valid & in_ready;

  always_comb begin
    is_deq     = (in_i.op == gtf_pkg::OpDeq);
    team_ext   = 32'(in_i.team_id);
    team_ok    = (team_ext < NUM_TEAMS);
    front_team = team_order_q[order_head_q];
    idx        = is_deq ? front_team : team_ext[OW-1:0];
    cnt        = member_count_q[idx];
    head       = member_head_q[idx];

    tail_sum   = (OCW+1)'(order_head_q) + (OCW+1)'(order_count_q);
    order_tail = (tail_sum >= (OCW+1)'(NUM_TEAMS)) ?
                 OW'(tail_sum - (OCW+1)'(NUM_TEAMS)) : OW'(tail_sum);

    order_head_inc = (OW+1)'(order_head_q) + (OW+1)'(1);
    order_head_nxt = (order_head_inc == (OW+1)'(NUM_TEAMS)) ? '0 : OW'(order_head_inc);

    head_inc   = (SLW+1)'(head) + (SLW+1)'(1);
    head_nxt   = (head_inc == (SLW+1)'(TEAM_DEPTH)) ? '0 : SLW'(head_inc);

    slot_sum   = (CW+1)'(head) + (CW+1)'(cnt);
    slot_tail  = (slot_sum >= (CW+1)'(TEAM_DEPTH)) ?
                 SLW'(slot_sum - (CW+1)'(TEAM_DEPTH)) : SLW'(slot_sum);

    slot       = is_deq ? head : slot_tail;
    store_addr = AW'(AW'(idx) * AW'(TEAM_DEPTH)) + AW'(slot);

    do_deq   = 1'b0;
    do_enq   = 1'b0;
    new_team = 1'b0;
    if (is_deq) begin
      if (order_count_q == '0 || cnt == '0) begin
        status_d = gtf_pkg::StEmpty;
      end else begin
        status_d = gtf_pkg::StDeq;
        do_deq   = 1'b1;
      end
    end else begin
      if (!team_ok || cnt >= CW'(TEAM_DEPTH)) begin
        status_d = gtf_pkg::StFull;
      end else if (cnt == '0 && order_count_q >= OCW'(NUM_TEAMS)) begin
        status_d = gtf_pkg::StFull;
      end else begin
        status_d = gtf_pkg::StEnq;
        do_enq   = 1'b1;
        new_team = (cnt == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_head_q  <= '0;
      order_count_q <= '0;
      res_valid_q   <= 1'b0;
      res_status_q  <= gtf_pkg::StEnq;
      for (int i = 0; i < NUM_TEAMS; i++) begin
        member_head_q[i]  <= '0;
        member_count_q[i] <= '0;
      end
    end else begin
      res_valid_q <= fire_in | (res_valid_q & ~res_pop);
      if (fire_in) begin
        res_status_q <= status_d;
        if (do_deq) begin
          member_head_q[idx]  <= head_nxt;
          member_count_q[idx] <= cnt - CW'(1);
          // last member leaves: the team drops out of the order
          if (cnt == CW'(1)) begin
            order_head_q  <= order_head_nxt;
            order_count_q <= order_count_q - OCW'(1);
          end
        end
        if (do_enq) begin
          member_count_q[idx] <= cnt + CW'(1);
          if (new_team) begin
            order_count_q <= order_count_q + OCW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_in && do_enq && new_team) begin
      team_order_q[order_tail] <= idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_in && do_enq) begin
      store_mem[store_addr] <= in_i.element[SW-1:0];
    end
    if (fire_in && do_deq) begin
      rd_data_q <= store_mem[store_addr];
    end
  end

  always_comb begin
    res.status  = res_status_q;
    res.element = (res_status_q == gtf_pkg::StDeq) ? gtf_pkg::ElemW'(rd_data_q) : '0;
  end

  gtf_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .res_valid_i (res_valid_q),
    .res_i       (res),
    .res_pop_o   (res_pop),
    .out_o       (out_o)
  );

  a_order_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    order_count_q <= OCW'(NUM_TEAMS))
    else $error("team order count exceeds number of teams");

  a_empty_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_in && is_deq && order_count_q == '0 |=> res_status_q == gtf_pkg::StEmpty)
    else $error("dequeue on empty queue not flagged");

  a_front_team_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_in && is_deq && order_count_q != '0 |-> cnt != '0)
    else $error("queued front team has no members");

  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with no result pending");

endmodule

`default_nettype wire
